### rtl/core/css_color_value_parser_core_defines.svh
// ----------------------------------------------------------------------------
// CSS color value parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CSS_COLOR_VALUE_PARSER_CORE_DEFINES_SVH
`define CSS_COLOR_VALUE_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cssp_pkg.sv
// ----------------------------------------------------------------------------
// CSS color value parser package
// Types, character constants and color name tables shared by the core.
// ----------------------------------------------------------------------------
package cssp_pkg;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_WORD      = 2'd1,
    MODE_HEX       = 2'd2,
    MODE_RGB       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // One result beat.
  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

  localparam int unsigned NumWords = 7;
  localparam logic [8:0]  AccMax   = 9'd511;
  localparam logic [8:0]  PctMax   = 9'd100;
  localparam logic [8:0]  CompMax  = 9'd255;
  // floor(v * 255 / 100) == (v * PctMul) >> 19 for v up to 100.
  localparam logic [27:0] PctMul   = 28'd1336965;
  localparam logic [7:0]  RgbBit   = 8'h80;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [7:0] WORD_TAB [NumWords][8] = '{
    '{"b", "l", "a", "c", "k", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00, 8'h00},
    '{"g", "r", "a", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] WORD_LEN [NumWords] = '{
    3'd5, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4
  };

  localparam logic [23:0] WORD_RGB [NumWords] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF,
    24'h008000, 24'h808080, 24'h808080
  };

  localparam logic [7:0] RGB_PREFIX [4] = '{"r", "g", "b", "("};

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= "0") && (c <= "9")) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if ((c >= "a") && (c <= "f")) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if ((c >= "A") && (c <= "F")) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Clamp to 100 and scale by 255/100, rounding down.
  function automatic logic [7:0] pct_scale(input logic [8:0] acc);
    logic [6:0]  v;
    logic [27:0] prod;
    v    = (acc > PctMax) ? 7'(PctMax) : acc[6:0];
    prod = 28'(v) * PctMul;
    return prod[26:19];
  endfunction

endpackage

### rtl/core/cssp_parse.sv
// ----------------------------------------------------------------------------
// CSS color value parser state stage
// Holds the per-value parse state and updates it once per accepted byte.
// ----------------------------------------------------------------------------
`include "css_color_value_parser_core_defines.svh"

module cssp_parse import cssp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output res_t       res_o
);

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  char_count_q, char_count_d;
  logic [1:0]  comp_idx_q, comp_idx_d;
  logic [8:0]  acc_q, acc_d;
  logic        percent_q, percent_d;
  logic [7:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [7:0]  name_hits_q, name_hits_d;
  logic        space_q, space_d;
  logic        closed_q, closed_d;
  logic        failed_q, failed_d;

  logic        sp;
  logic        is_dig;
  logic [3:0]  dig_val;
  logic [7:0]  lc;
  logic [4:0]  hexd;
  logic        word_step;
  logic        do_trail;
  logic [12:0] acc_mul;
  logic [7:0]  comp_val;
  logic [23:0] hex_word;
  logic        found;
  logic        ok;
  logic [23:0] rgb;

  assign sp      = is_space(char_byte_i);
  assign is_dig  = (char_byte_i >= "0") && (char_byte_i <= "9");
  assign dig_val = char_byte_i[3:0];
  assign lc      = ((char_byte_i >= "A") && (char_byte_i <= "Z")) ?
                   (char_byte_i + 8'd32) : char_byte_i;
  assign hexd    = hex_digit(char_byte_i);
  assign acc_mul = 13'(acc_q) * 13'd10 + 13'(dig_val);
  assign hex_word = {red_q, green_q, blue_q};

  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    char_count_d = char_count_q;
    comp_idx_d   = comp_idx_q;
    acc_d        = acc_q;
    percent_d    = percent_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    name_hits_d  = name_hits_q;
    space_d      = space_q;
    closed_d     = closed_q;
    failed_d     = failed_q;
    word_step    = 1'b0;
    do_trail     = 1'b0;
    comp_val     = 8'd0;
    found        = 1'b0;
    ok           = 1'b0;
    rgb          = 24'd0;

    if (accept_i && !failed_q) begin
      unique case (mode_q)
        MODE_UNDECIDED: begin
          if (!sp) begin
            if (char_byte_i == CH_HASH) begin
              mode_d = MODE_HEX;
            end else begin
              mode_d    = MODE_WORD;
              word_step = 1'b1;
            end
          end
        end
        MODE_WORD: begin
          if (sp) begin
            space_d = 1'b1;
          end else if (space_q) begin
            failed_d = 1'b1;
          end else begin
            word_step = 1'b1;
          end
        end
        MODE_HEX: begin
          if (sp) begin
            space_d = 1'b1;
          end else if (space_q || !hexd[4]) begin
            failed_d = 1'b1;
          end else begin
            {red_d, green_d, blue_d} = {hex_word[19:0], hexd[3:0]};
            if (char_count_q != 3'd7) begin
              char_count_d = char_count_q + 3'd1;
            end
          end
        end
        MODE_RGB: begin
          if (!sp) begin
            closed_d = (char_byte_i == CH_RPAREN);
          end
          unique case (phase_q)
            PH_LEAD: begin
              if (is_dig) begin
                acc_d   = 9'(dig_val);
                phase_d = PH_DIGITS;
              end else if (!sp) begin
                failed_d = 1'b1;
              end
            end
            PH_DIGITS: begin
              if (is_dig) begin
                acc_d = (acc_mul > 13'(AccMax)) ? AccMax : acc_mul[8:0];
              end else begin
                percent_d = (char_byte_i == CH_PCT);
                if (percent_d) begin
                  comp_val = pct_scale(acc_q);
                end else begin
                  comp_val = (acc_q > CompMax) ? 8'hFF : acc_q[7:0];
                end
                unique case (comp_idx_q)
                  2'd0:    red_d   = comp_val;
                  2'd1:    green_d = comp_val;
                  default: blue_d  = comp_val;
                endcase
                if (comp_idx_q >= 2'd2) begin
                  phase_d = PH_DONE;
                end else begin
                  phase_d  = PH_TRAIL;
                  do_trail = !percent_d;
                end
              end
            end
            PH_TRAIL: do_trail = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // A comma moves on to the next component; anything else but space fails.
    if (do_trail && !sp) begin
      if ((char_byte_i == CH_COMMA) && (comp_idx_q < 2'd2)) begin
        comp_idx_d = comp_idx_q + 2'd1;
        phase_d    = PH_LEAD;
      end else begin
        failed_d = 1'b1;
      end
    end

    // Name matching: drop every candidate that disagrees at this position.
    if (word_step) begin
      for (int k = 0; k < NumWords; k++) begin
        if (name_hits_q[k] && ((char_count_q >= WORD_LEN[k]) ||
            (WORD_TAB[k][char_count_q] != lc))) begin
          name_hits_d[k] = 1'b0;
        end
      end
      if (name_hits_q[7] && ((char_count_q >= 3'd4) ||
          (RGB_PREFIX[char_count_q[1:0]] != lc))) begin
        name_hits_d[7] = 1'b0;
      end
      if (char_count_q != 3'd7) begin
        char_count_d = char_count_q + 3'd1;
      end
      if (name_hits_d[7] && (char_count_q == 3'd3)) begin
        mode_d      = MODE_RGB;
        phase_d     = PH_LEAD;
        comp_idx_d  = 2'd0;
        name_hits_d = 8'd0;
      end else if (name_hits_d == 8'd0) begin
        failed_d = 1'b1;
      end
    end

    // Final verdict is taken from the state after this byte.
    if (!failed_d) begin
      unique case (mode_d)
        MODE_WORD: begin
          for (int k = 0; k < NumWords; k++) begin
            if (!found && name_hits_d[k] && (char_count_d == WORD_LEN[k])) begin
              found = 1'b1;
              rgb   = WORD_RGB[k];
            end
          end
          ok = found;
        end
        MODE_HEX: begin
          if (char_count_d == 3'd6) begin
            ok  = 1'b1;
            rgb = {red_d, green_d, blue_d};
          end else if (char_count_d == 3'd3) begin
            ok  = 1'b1;
            rgb = {green_d[3:0], green_d[3:0], blue_d[7:4], blue_d[7:4],
                   blue_d[3:0], blue_d[3:0]};
          end
        end
        MODE_RGB: begin
          if ((phase_d == PH_DONE) && closed_d) begin
            ok  = 1'b1;
            rgb = {red_d, green_d, blue_d};
          end
        end
        default: ;
      endcase
    end
    if (!ok) begin
      rgb = 24'd0;
    end

    // The value is complete: start clean for the next one.
    if (accept_i && last_byte_i) begin
      mode_d       = MODE_UNDECIDED;
      phase_d      = PH_LEAD;
      char_count_d = 3'd0;
      comp_idx_d   = 2'd0;
      acc_d        = 9'd0;
      percent_d    = 1'b0;
      red_d        = 8'd0;
      green_d      = 8'd0;
      blue_d       = 8'd0;
      name_hits_d  = 8'hFF;
      space_d      = 1'b0;
      closed_d     = 1'b0;
      failed_d     = 1'b0;
    end
  end

  assign push_o          = accept_i && last_byte_i;
  assign res_o.valid_res = ok;
  assign res_o.red       = rgb[23:16];
  assign res_o.green     = rgb[15:8];
  assign res_o.blue      = rgb[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_UNDECIDED;
      phase_q      <= PH_LEAD;
      char_count_q <= 3'd0;
      comp_idx_q   <= 2'd0;
      acc_q        <= 9'd0;
      percent_q    <= 1'b0;
      red_q        <= 8'd0;
      green_q      <= 8'd0;
      blue_q       <= 8'd0;
      name_hits_q  <= 8'hFF;
      space_q      <= 1'b0;
      closed_q     <= 1'b0;
      failed_q     <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      char_count_q <= char_count_d;
      comp_idx_q   <= comp_idx_d;
      acc_q        <= acc_d;
      percent_q    <= percent_d;
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      name_hits_q  <= name_hits_d;
      space_q      <= space_d;
      closed_q     <= closed_d;
      failed_q     <= failed_d;
    end
  end

  `CSSP_ASSERT_NEXT(a_fail_sticky, failed_q && !(accept_i && last_byte_i), failed_q, "failure flag dropped before end of value")
  `CSSP_ASSERT_NEXT(a_last_clears, accept_i && last_byte_i, (mode_q == MODE_UNDECIDED) && !failed_q && (name_hits_q == 8'hFF), "state not cleared after last beat")
  `CSSP_ASSERT_SAME(a_rgb_no_names, mode_q == MODE_RGB, (name_hits_q & ~RgbBit) == 8'd0, "name candidates alive in rgb mode")

endmodule

### rtl/core/cssp_out_fifo.sv
// ----------------------------------------------------------------------------
// CSS color value parser result buffer
// Two-entry register FIFO that decouples the result channel from the input.
// ----------------------------------------------------------------------------
`include "css_color_value_parser_core_defines.svh"

module cssp_out_fifo import cssp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  `CSSP_ASSERT_SAME(a_no_overflow, cnt_q == 2'd2, !push_i, "result pushed into a full buffer")
  `CSSP_ASSERT_NEXT(a_pop_drains, pop && !push_i, cnt_q == $past(cnt_q) - 2'd1, "pop did not drain an entry")
  `CSSP_ASSERT_NEXT(a_push_fills, push_i && !pop, cnt_q == $past(cnt_q) + 2'd1, "push did not fill an entry")

endmodule

### rtl/core/css_color_value_parser_core.sv
// ----------------------------------------------------------------------------
// CSS color value parser core
// Parses rgb(), #rgb / #rrggbb and named colors from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of the value text per beat, with
//   last_byte_i marking the final byte. Leading and trailing whitespace is
//   trimmed. Only the beat with last_byte_i set yields a result beat on the
//   output channel: valid_res_o and the red, green and blue channels, all
//   zero when the text is not a color.
//   Bytes are accepted at one beat per cycle while the result buffer has
//   space. A result is written into the result buffer when its last byte is
//   accepted; the parse state update and verdict are one shallow pass between
//   the state registers and a two-entry result buffer.
//   When the receiver stalls, up to two results are held; in_ready_o falls
//   only while both entries are full.
//   Reset clears the parse state and empties the result buffer; the block
//   is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module css_color_value_parser_core import cssp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic accept;
  logic push;
  logic space;
  res_t res_new;
  res_t res_out;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  cssp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .res_o       (res_new)
  );

  cssp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_new),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign valid_res_o = res_out.valid_res;
  assign red_o       = res_out.red;
  assign green_o     = res_out.green;
  assign blue_o      = res_out.blue;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS color value parser testbench
// Streams color values one byte per beat through the core: a short table of
// directed values, then random rgb(), hex, named and malformed values under
// changing sender and receiver stalls. A cycle-free parser model predicts each
// result beat that no directed row types itself; beats are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench import cssp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BEATS  = 1150;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned DIRECTED_ROWS = 26;

  localparam res_t NO_COLOR    = '0;
  localparam res_t WHITE_COLOR = {1'b1, 24'hFFFFFF};
  localparam res_t RED_COLOR   = {1'b1, 24'hFF0000};

  localparam logic [31:0] RGB_OPEN = "rgb(";
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [8:0]  ACC_TOP  = 9'd511;

  typedef enum logic [1:0] {
    FORM_RGB,
    FORM_HEX,
    FORM_NAME
  } form_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    res_t       want;
  } stim_row_t;

  typedef struct packed {
    logic [39:0] text;
    logic [2:0]  len;
    logic [23:0] rgb;
  } color_name_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       valid_res_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  // Typed expectation travelling with the beat, used by the directed table.
  logic beat_typed = 1'b0;
  res_t beat_want  = '0;

  int unsigned send_idle   = 20;
  int unsigned recv_idle   = 63;
  int unsigned send_plan [3] = '{20, 63, 0};
  int unsigned recv_plan [3] = '{63, 20, 0};
  int unsigned cycle_count = 0;
  int unsigned errors      = 0;
  int unsigned beats_sent  = 0;
  int unsigned values_sent = 0;
  int unsigned colors_seen = 0;
  int unsigned valid_seen  = 0;

  res_t       expected_colors [$];
  logic [7:0] value_text [$];

  // Shadow copy of the parse state.
  mode_e      shadow_mode;
  logic [2:0] shadow_count;
  logic [1:0] shadow_index;
  phase_e     shadow_phase;
  logic [8:0] shadow_acc;
  logic       shadow_pct;
  logic [7:0] shadow_red;
  logic [7:0] shadow_green;
  logic [7:0] shadow_blue;
  logic [7:0] shadow_hits;
  logic       shadow_gap;
  logic       shadow_closed;
  logic       shadow_failed;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    {CH_SPACE, 1'b1, 1'b1, NO_COLOR},
    {8'h00,    1'b1, 1'b1, NO_COLOR},
    {8'hFF,    1'b1, 1'b1, NO_COLOR},
    {CH_HASH,  1'b0, 1'b0, NO_COLOR},
    {"f",      1'b0, 1'b0, NO_COLOR},
    {"F",      1'b0, 1'b0, NO_COLOR},
    {"f",      1'b1, 1'b1, WHITE_COLOR},
    {"R",      1'b0, 1'b0, NO_COLOR},
    {"e",      1'b0, 1'b0, NO_COLOR},
    {"d",      1'b1, 1'b1, RED_COLOR},
    {"r",      1'b0, 1'b0, NO_COLOR},
    {"g",      1'b0, 1'b0, NO_COLOR},
    {"b",      1'b0, 1'b0, NO_COLOR},
    {"(",      1'b0, 1'b0, NO_COLOR},
    {"1",      1'b0, 1'b0, NO_COLOR},
    {CH_PCT,   1'b0, 1'b0, NO_COLOR},
    {CH_COMMA, 1'b0, 1'b0, NO_COLOR},
    {"9",      1'b0, 1'b0, NO_COLOR},
    {"9",      1'b0, 1'b0, NO_COLOR},
    {"9",      1'b0, 1'b0, NO_COLOR},
    {CH_COMMA, 1'b0, 1'b0, NO_COLOR},
    {"0",      1'b0, 1'b0, NO_COLOR},
    {CH_RPAREN, 1'b1, 1'b0, NO_COLOR},
    {"b",      1'b0, 1'b0, NO_COLOR},
    {CH_TAB,   1'b0, 1'b0, NO_COLOR},
    {"x",      1'b1, 1'b1, NO_COLOR}
  };

  always #1 clk_i = ~clk_i;

  css_color_value_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  function automatic color_name_t color_name(input int k);
    case (k)
      0:       return {"black", 3'd5, 24'h000000};
      1:       return {"white", 3'd5, 24'hFFFFFF};
      2:       return {"red", 16'h0, 3'd3, 24'hFF0000};
      3:       return {"blue", 8'h0, 3'd4, 24'h0000FF};
      4:       return {"green", 3'd5, 24'h008000};
      5:       return {"gray", 8'h0, 3'd4, 24'h808080};
      default: return {"grey", 8'h0, 3'd4, 24'h808080};
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if ((c >= "0") && (c <= "9")) return int'(c) - int'("0");
    if ((c >= "a") && (c <= "f")) return int'(c) - int'("a") + 10;
    if ((c >= "A") && (c <= "F")) return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void clear_parse();
    shadow_mode   = MODE_UNDECIDED;
    shadow_count  = '0;
    shadow_index  = '0;
    shadow_phase  = PH_LEAD;
    shadow_acc    = '0;
    shadow_pct    = 1'b0;
    shadow_red    = '0;
    shadow_green  = '0;
    shadow_blue   = '0;
    shadow_hits   = 8'hFF;
    shadow_gap    = 1'b0;
    shadow_closed = 1'b0;
    shadow_failed = 1'b0;
  endfunction

  // Narrows the name candidates; bit 7 tracks the rgb( opener.
  function automatic void match_word(input logic [7:0] c);
    logic [7:0]  lc;
    int          pos;
    color_name_t nm;
    lc  = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    pos = shadow_count;
    for (int k = 0; k < 7; k++) begin
      nm = color_name(k);
      if (shadow_hits[k]) begin
        if (pos >= nm.len) begin
          shadow_hits[k] = 1'b0;
        end else if (nm.text[39 - 8 * pos -: 8] != lc) begin
          shadow_hits[k] = 1'b0;
        end
      end
    end
    if (shadow_hits[7]) begin
      if (pos >= 4) begin
        shadow_hits[7] = 1'b0;
      end else if (RGB_OPEN[31 - 8 * pos -: 8] != lc) begin
        shadow_hits[7] = 1'b0;
      end
    end
    if (shadow_count < 3'd7) shadow_count++;
    if (shadow_hits[7] && (pos == 3)) begin
      shadow_mode  = MODE_RGB;
      shadow_phase = PH_LEAD;
      shadow_index = '0;
      shadow_hits  = '0;
      return;
    end
    if (shadow_hits == '0) shadow_failed = 1'b1;
  endfunction

  function automatic void close_component();
    int v;
    v = shadow_acc;
    if (shadow_pct) begin
      if (v > 100) v = 100;
      v = v * 255 / 100;
    end else if (v > 255) begin
      v = 255;
    end
    case (shadow_index)
      2'd0:    shadow_red   = 8'(v);
      2'd1:    shadow_green = 8'(v);
      default: shadow_blue  = 8'(v);
    endcase
  endfunction

  function automatic void separator_byte(input logic [7:0] c, input logic sp);
    if (sp) return;
    if ((c == CH_COMMA) && (shadow_index < 2'd2)) begin
      shadow_index++;
      shadow_phase = PH_LEAD;
    end else begin
      shadow_failed = 1'b1;
    end
  endfunction

  function automatic void component_byte(input logic [7:0] c, input logic sp);
    int   a;
    logic digit;
    digit = (c >= "0") && (c <= "9");
    case (shadow_phase)
      PH_LEAD: begin
        if (digit) begin
          shadow_acc   = 9'(int'(c) - int'("0"));
          shadow_phase = PH_DIGITS;
        end else if (!sp) begin
          shadow_failed = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          a = int'(shadow_acc) * 10 + int'(c) - int'("0");
          shadow_acc = (a > int'(ACC_TOP)) ? ACC_TOP : 9'(a);
        end else begin
          shadow_pct = (c == CH_PCT);
          close_component();
          if (shadow_index >= 2'd2) begin
            shadow_phase = PH_DONE;
          end else begin
            shadow_phase = PH_TRAIL;
            if (!shadow_pct) separator_byte(c, sp);
          end
        end
      end
      PH_TRAIL: separator_byte(c, sp);
      default: ;
    endcase
  endfunction

  function automatic void feed_byte(input logic [7:0] c);
    logic sp;
    int   h;
    sp = is_blank(c);
    case (shadow_mode)
      MODE_UNDECIDED: begin
        if (!sp) begin
          if (c == CH_HASH) begin
            shadow_mode = MODE_HEX;
          end else begin
            shadow_mode = MODE_WORD;
            match_word(c);
          end
        end
      end
      MODE_WORD: begin
        if (sp) shadow_gap = 1'b1;
        else if (shadow_gap) shadow_failed = 1'b1;
        else match_word(c);
      end
      MODE_HEX: begin
        h = nibble_of(c);
        if (sp) begin
          shadow_gap = 1'b1;
        end else if (shadow_gap || (h < 0)) begin
          shadow_failed = 1'b1;
        end else begin
          {shadow_red, shadow_green, shadow_blue} =
              {shadow_red[3:0], shadow_green, shadow_blue, 4'(h)};
          if (shadow_count < 3'd7) shadow_count++;
        end
      end
      default: begin
        if (!sp) shadow_closed = (c == CH_RPAREN);
        component_byte(c, sp);
      end
    endcase
  endfunction

  // Advances the parse by one byte; on the last byte returns 1 with the verdict.
  function automatic bit step_color(input logic [7:0] c, input logic last,
                                    output res_t verdict);
    color_name_t nm;
    verdict = NO_COLOR;
    if (!shadow_failed) feed_byte(c);
    if (!last) return 1'b0;
    if (!shadow_failed) begin
      case (shadow_mode)
        MODE_WORD: begin
          for (int k = 0; k < 7; k++) begin
            nm = color_name(k);
            if (shadow_hits[k] && (shadow_count == nm.len)) begin
              verdict = {1'b1, nm.rgb};
              break;
            end
          end
        end
        MODE_HEX: begin
          if (shadow_count == 3'd6) begin
            verdict = {1'b1, shadow_red, shadow_green, shadow_blue};
          end else if (shadow_count == 3'd3) begin
            verdict = {1'b1, 8'(shadow_green[3:0] * 8'd17),
                       8'(shadow_blue[7:4] * 8'd17), 8'(shadow_blue[3:0] * 8'd17)};
          end
        end
        MODE_RGB: begin
          if ((shadow_phase == PH_DONE) && shadow_closed) begin
            verdict = {1'b1, shadow_red, shadow_green, shadow_blue};
          end
        end
        default: ;
      endcase
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if ((((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")))
        && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic void pad_blanks(input int unsigned most);
    repeat ($urandom_range(0, most)) value_text.push_back(any_blank());
  endfunction

  function automatic void push_number();
    int unsigned v;
    string       s;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 99999);
      1, 2:    v = $urandom_range(0, 9);
      default: v = $urandom_range(0, 300);
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    for (int i = 0; i < s.len(); i++) value_text.push_back(s[i]);
  endfunction

  function automatic void push_rgb();
    for (int i = 0; i < 4; i++) value_text.push_back(mixed_case(RGB_OPEN[31 - 8 * i -: 8]));
    for (int k = 0; k < 3; k++) begin
      pad_blanks(2);
      push_number();
      if ($urandom_range(0, 3) == 0) value_text.push_back(CH_PCT);
      pad_blanks(1);
      if (k < 2) value_text.push_back(CH_COMMA);
    end
    // Bytes after the third component has ended, up to the closing paren, are skipped.
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) value_text.push_back(8'($urandom_range(0, 255)));
    end
    value_text.push_back(CH_RPAREN);
  endfunction

  function automatic void push_hex();
    int unsigned digits;
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: digits = 3;
      4, 5, 6, 7: digits = 6;
      default:    digits = $urandom_range(0, 8);
    endcase
    value_text.push_back(CH_HASH);
    repeat (digits) begin
      v = $urandom_range(0, 15);
      value_text.push_back(mixed_case((v < 10) ? 8'("0" + v) : 8'("a" + v - 10)));
    end
  endfunction

  function automatic void push_name();
    color_name_t nm;
    nm = color_name($urandom_range(0, 6));
    for (int i = 0; i < nm.len; i++) value_text.push_back(mixed_case(nm.text[39 - 8 * i -: 8]));
  endfunction

  function automatic void mangle_value();
    int unsigned at;
    at = $urandom_range(0, value_text.size() - 1);
    case ($urandom_range(0, 2))
      0: value_text[at] = 8'($urandom_range(0, 255));
      1: while (value_text.size() > at + 1) void'(value_text.pop_back());
      default: value_text.insert(at, any_blank());
    endcase
  endfunction

  function automatic void build_value();
    int unsigned pick;
    form_e       form;
    pick = $urandom_range(0, 99);
    value_text.delete();
    if (pick < 15) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) value_text.push_back(any_blank());
      end else begin
        repeat ($urandom_range(1, 6)) value_text.push_back(8'($urandom_range(0, 255)));
      end
      return;
    end
    if (pick < 45) form = FORM_RGB;
    else if (pick < 65) form = FORM_HEX;
    else if (pick < 85) form = FORM_NAME;
    else form = form_e'($urandom_range(0, 2));
    pad_blanks(2);
    case (form)
      FORM_RGB: push_rgb();
      FORM_HEX: push_hex();
      default:  push_name();
    endcase
    pad_blanks(2);
    if (pick >= 85) mangle_value();
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic last, input logic typed,
                           input res_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= ch;
    last_byte_i <= last;
    beat_typed  <= typed;
    beat_want   <= want;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (last) values_sent++;
  endtask

  task automatic send_value();
    for (int i = 0; i < value_text.size(); i++) begin
      send_beat(value_text[i], i == value_text.size() - 1, 1'b0, NO_COLOR);
    end
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_colors.size() != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_colors.size());
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    res_t verdict;
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (step_color(char_byte_i, last_byte_i, verdict)) begin
          expected_colors.push_back(beat_typed ? beat_want : verdict);
        end
      end
      if (out_valid_o && out_ready_i) begin
        colors_seen++;
        if (valid_res_o) valid_seen++;
        if (expected_colors.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("cycle %0d: result beat with nothing expected: valid=%0b rgb=%02h%02h%02h",
                     cycle_count, valid_res_o, red_o, green_o, blue_o);
          end
        end else begin
          want = expected_colors.pop_front();
          if ((valid_res_o !== want.valid_res) || (red_o !== want.red)
              || (green_o !== want.green) || (blue_o !== want.blue)) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("cycle %0d: expected valid=%0b rgb=%02h%02h%02h, got valid=%0b rgb=%02h%02h%02h",
                       cycle_count, want.valid_res, want.red, want.green, want.blue,
                       valid_res_o, red_o, green_o, blue_o);
            end
          end
        end
      end
    end
  end

  initial begin
    clear_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    end
    wait_quiet();
    for (int p = 0; p < 3; p++) begin
      send_idle = send_plan[p];
      recv_idle = recv_plan[p];
      while (beats_sent < DIRECTED_ROWS + (p + 1) * RANDOM_BEATS / 3) begin
        build_value();
        send_value();
      end
      wait_quiet();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_colors.size() != 0) begin
      $display("%0d expected results never arrived", expected_colors.size());
      errors += expected_colors.size();
    end
    $display("covered %0d beats in %0d values: %0d result beats, %0d of them colors",
             beats_sent, values_sent, colors_seen, valid_seen);
    $display("stall mix: sender/receiver 20/63, then 63/20, then none; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
